/* hw/rtl/wphc_pkg.sv */
// Package for the windowed PID heater controller.
// Transaction structs, register indexes, scan states and fixed widths.
// No dependencies.
`default_nettype none

package wphc_pkg;

  localparam int TEMP_W     = 12;
  localparam int GAIN_W     = 16;
  localparam int ERR_W      = TEMP_W + 1;
  localparam int DER_W      = ERR_W + 1;
  localparam int WLEN_W     = 5;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int PWM_W      = 8;
  localparam int DRV_OUT_W  = 16;
  localparam int FRAC_SH    = 12;
  localparam int PWM_MAX    = 255;
  localparam int DRV_MAX    = 32767;
  localparam int DRV_MIN    = -32768;

  localparam logic signed [TEMP_W-1:0] TARGET_RST     = 12'sd592;
  localparam logic signed [GAIN_W-1:0] P_GAIN_RST     = 16'sd256;
  localparam logic signed [GAIN_W-1:0] I_GAIN_RST     = 16'sd0;
  localparam logic signed [GAIN_W-1:0] D_GAIN_RST     = 16'sd0;
  localparam logic signed [TEMP_W-1:0] PAD_LIMIT_RST  = 12'sd640;
  localparam logic signed [TEMP_W-1:0] ROOM_LIMIT_RST = 12'sd560;
  localparam logic [WLEN_W-1:0]        WINDOW_LEN_RST = 5'd10;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_TARGET     = 3'd0,
    REG_P_GAIN     = 3'd1,
    REG_I_GAIN     = 3'd2,
    REG_D_GAIN     = 3'd3,
    REG_PAD_LIMIT  = 3'd4,
    REG_ROOM_LIMIT = 3'd5,
    REG_WINDOW_LEN = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_SCAN,
    ST_DRAIN
  } scan_state_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] core_temp;
    logic signed [TEMP_W-1:0] pad_temp;
    logic signed [TEMP_W-1:0] room_temp;
  } in_t;

  typedef struct packed {
    logic [PWM_W-1:0]            pad_pwm;
    logic                        room_heater_on;
    logic signed [DRV_OUT_W-1:0] drive_unclamped;
  } out_t;

endpackage

`default_nettype wire

/* hw/rtl/windowed_pid_heater_control_top.sv */
// Windowed PID heater controller: error ring in RAM, running window sum, PID drive.
// Throughput one transaction per cycle while neither out_stall nor a rescan stalls the input,
// set by the read-first error RAM that is read and written once per transaction.
// A window_len write starts a rescan of the error RAM (scan, then drain), input stalled.
// Reset (rst_n low, synchronous): configuration and control registers to defaults, ring entries read as zero.
// Depends on wphc_pkg and wphc_ram.
`default_nettype none

module windowed_pid_heater_control_top #(
  parameter int WINDOW_MAX = 16
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  wphc_pkg::in_t                        in_data,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output wphc_pkg::out_t                       out_data,
  input  wire                                  cfg_we,
  input  wire [wphc_pkg::CFG_ADDR_W-1:0]       cfg_addr,
  input  wire [wphc_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import wphc_pkg::*;

  localparam int IDX_W = $clog2(WINDOW_MAX);
  localparam int LEN_W = $clog2(WINDOW_MAX + 1);
  localparam int SUM_W = ERR_W + LEN_W;
  localparam int PE_W  = GAIN_W + ERR_W;
  localparam int DE_W  = GAIN_W + DER_W;
  localparam int ACC_W = GAIN_W + SUM_W + 2;
  localparam int DRV_W = ACC_W - FRAC_SH;

  logic signed [TEMP_W-1:0] target_temp_r, pad_limit_r, room_limit_r;
  logic signed [GAIN_W-1:0] p_gain_r, i_gain_r, d_gain_r;
  logic [WLEN_W-1:0]        window_len_r;

  scan_state_t state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic             scan_rd, scan_go, scan_acc_r, scan_acc_nxt;
  logic [IDX_W-1:0] scan_idx_r;

  logic [IDX_W-1:0]        window_index_r, window_index_nxt, widx;
  logic [WINDOW_MAX-1:0]   entry_vld_r;
  logic                    rd_vbit_r;
  logic signed [SUM_W-1:0] sum_r, sum_nxt, sum_new;
  logic signed [ERR_W-1:0] last_err_r;

  logic [31:0]      wl32, len32, nxt32;
  logic [LEN_W-1:0] len_eff;

  logic                    acc_in;
  logic signed [ERR_W-1:0] err, old_e;
  logic signed [DER_W-1:0] deriv;
  logic [ERR_W-1:0]        ram_rdata;
  logic                    ram_re;
  logic [IDX_W-1:0]        ram_raddr;

  logic                    v1_r, v2_r, v3_r, out_valid_r;
  logic                    mv1, mv2, mv3, free1, free2, free3;
  logic signed [ERR_W-1:0] err1_r;
  logic signed [DER_W-1:0] der1_r;
  logic                    pad_hot1_r, room_on1_r, pad_hot2_r, room_on2_r;
  logic                    pad_hot3_r, room_on3_r;
  logic signed [PE_W-1:0]  pe2_r;
  logic signed [DE_W-1:0]  de2_r;
  logic signed [SUM_W-1:0] sum2_r;
  logic signed [ACC_W-1:0] pd3_r, is3_r, acc_sum;
  logic signed [DRV_W-1:0] drive;
  out_t                    out_data_r, out_nxt;

  // effective window length and ring position
  always_comb begin
    wl32 = 32'(window_len_r);
    if (wl32 == 32'd0) begin
      len32 = 32'd1;
    end else if (wl32 > 32'(WINDOW_MAX)) begin
      len32 = 32'(WINDOW_MAX);
    end else begin
      len32 = wl32;
    end
    len_eff = len32[LEN_W-1:0];
    widx = (32'(window_index_r) >= 32'(len_eff)) ? '0 : window_index_r;
    nxt32 = 32'(widx) + 32'd1;
    window_index_nxt = (nxt32 >= 32'(len_eff)) ? '0 : nxt32[IDX_W-1:0];
  end

  // stage handshake
  always_comb begin
    free3    = !v3_r || !out_valid_r || !out_stall;
    mv3      = v3_r && free3;
    free2    = !v2_r || free3;
    mv2      = v2_r && free3;
    free1    = !v1_r || free2;
    mv1      = v1_r && free2;
    in_stall = (state_r != ST_RUN) || !free1;
    acc_in   = in_valid && !in_stall;
  end

  assign err   = ERR_W'(target_temp_r) - ERR_W'(in_data.core_temp);
  assign deriv = DER_W'(err) - DER_W'(last_err_r);
  assign scan_go = cfg_we && (cfg_addr == REG_WINDOW_LEN);

  // rescan sequencer
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    scan_rd      = 1'b0;
    scan_acc_nxt = 1'b0;
    unique case (state_r)
      ST_RUN: begin
        cnt_nxt = '0;
      end
      ST_SCAN: begin
        scan_rd      = 1'b1;
        scan_acc_nxt = 1'b1;
        cnt_nxt      = cnt_r + IDX_W'(1);
        if (cnt_r == IDX_W'(WINDOW_MAX - 1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_RUN;
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
    if (scan_go) begin
      state_nxt    = ST_SCAN;
      cnt_nxt      = '0;
      scan_acc_nxt = 1'b0;
    end
  end

  assign ram_re    = acc_in || scan_rd;
  assign ram_raddr = scan_rd ? cnt_r : widx;

  wphc_ram #(
    .WIDTH(ERR_W),
    .DEPTH(WINDOW_MAX)
  ) u_err_ram (
    .clk  (clk),
    .we   (acc_in),
    .waddr(widx),
    .wdata(err),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign old_e   = rd_vbit_r ? $signed(ram_rdata) : '0;
  assign sum_new = sum_r - SUM_W'(old_e) + SUM_W'(err1_r);

  always_comb begin
    sum_nxt = sum_r;
    if (scan_go) begin
      sum_nxt = '0;
    end else if (scan_acc_r) begin
      if (rd_vbit_r && (32'(scan_idx_r) < 32'(len_eff))) begin
        sum_nxt = sum_r + SUM_W'(old_e);
      end
    end else if (mv1) begin
      sum_nxt = sum_new;
    end
  end

  assign acc_sum = pd3_r + is3_r;
  assign drive   = $signed(acc_sum[ACC_W-1:FRAC_SH]);

  always_comb begin
    out_nxt.room_heater_on = room_on3_r;
    if (drive > DRV_W'(DRV_MAX)) begin
      out_nxt.drive_unclamped = DRV_OUT_W'(DRV_MAX);
    end else if (drive < DRV_W'(DRV_MIN)) begin
      out_nxt.drive_unclamped = DRV_OUT_W'(DRV_MIN);
    end else begin
      out_nxt.drive_unclamped = drive[DRV_OUT_W-1:0];
    end
    priority if (pad_hot3_r || (drive < DRV_W'(0))) begin
      out_nxt.pad_pwm = '0;
    end else if (drive > DRV_W'(PWM_MAX)) begin
      out_nxt.pad_pwm = PWM_W'(PWM_MAX);
    end else begin
      out_nxt.pad_pwm = drive[PWM_W-1:0];
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_temp_r <= TARGET_RST;
      p_gain_r      <= P_GAIN_RST;
      i_gain_r      <= I_GAIN_RST;
      d_gain_r      <= D_GAIN_RST;
      pad_limit_r   <= PAD_LIMIT_RST;
      room_limit_r  <= ROOM_LIMIT_RST;
      window_len_r  <= WINDOW_LEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_TARGET:     target_temp_r <= $signed(cfg_data[TEMP_W-1:0]);
        REG_P_GAIN:     p_gain_r      <= $signed(cfg_data[GAIN_W-1:0]);
        REG_I_GAIN:     i_gain_r      <= $signed(cfg_data[GAIN_W-1:0]);
        REG_D_GAIN:     d_gain_r      <= $signed(cfg_data[GAIN_W-1:0]);
        REG_PAD_LIMIT:  pad_limit_r   <= $signed(cfg_data[TEMP_W-1:0]);
        REG_ROOM_LIMIT: room_limit_r  <= $signed(cfg_data[TEMP_W-1:0]);
        REG_WINDOW_LEN: window_len_r  <= cfg_data[WLEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_RUN;
      cnt_r          <= '0;
      scan_acc_r     <= 1'b0;
      window_index_r <= '0;
      entry_vld_r    <= '0;
      sum_r          <= '0;
      last_err_r     <= '0;
      v1_r           <= 1'b0;
      v2_r           <= 1'b0;
      v3_r           <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      scan_acc_r <= scan_acc_nxt;
      sum_r      <= sum_nxt;
      if (acc_in) begin
        window_index_r    <= window_index_nxt;
        entry_vld_r[widx] <= 1'b1;
        last_err_r        <= err;
      end
      if (free1) begin
        v1_r <= acc_in;
      end
      if (free2) begin
        v2_r <= mv1;
      end
      if (free3) begin
        v3_r <= mv2;
      end
      if (!out_valid_r || !out_stall) begin
        out_valid_r <= mv3;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (ram_re) begin
      rd_vbit_r  <= scan_rd ? entry_vld_r[cnt_r] : entry_vld_r[widx];
      scan_idx_r <= cnt_r;
    end
    if (acc_in) begin
      err1_r     <= err;
      der1_r     <= deriv;
      pad_hot1_r <= in_data.pad_temp > pad_limit_r;
      room_on1_r <= !(in_data.room_temp > room_limit_r);
    end
    if (mv1) begin
      pe2_r      <= PE_W'(p_gain_r) * PE_W'(err1_r);
      de2_r      <= DE_W'(d_gain_r) * DE_W'(der1_r);
      sum2_r     <= sum_new;
      pad_hot2_r <= pad_hot1_r;
      room_on2_r <= room_on1_r;
    end
    if (mv2) begin
      pd3_r      <= ACC_W'(pe2_r) + ACC_W'(de2_r);
      is3_r      <= ACC_W'(i_gain_r) * ACC_W'(sum2_r);
      pad_hot3_r <= pad_hot2_r;
      room_on3_r <= room_on2_r;
    end
    if (mv3) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

/* hw/rtl/wphc_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
// Read-first on a same-address write. No dependencies.
`default_nettype none

module wphc_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 16
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(DEPTH)-1:0] waddr,
  input  wire [WIDTH-1:0]         wdata,
  input  wire                     re,
  input  wire [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/wphc_checker.sv */
// Port-level checker for the windowed PID heater controller, bound to the top level.
// Depends on wphc_pkg.
`default_nettype none

module wphc_checker (
  input wire                             clk,
  input wire                             rst_n,
  input wire                             in_stall,
  input wire                             out_valid,
  input wire                             out_stall,
  input wphc_pkg::out_t                  out_data,
  input wire                             cfg_we,
  input wire [wphc_pkg::CFG_ADDR_W-1:0]  cfg_addr
);
  import wphc_pkg::*;

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result transaction right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result transaction changed");

  a_pwm_le_drive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.pad_pwm == '0) ||
                  (out_data.drive_unclamped >= $signed({8'h00, out_data.pad_pwm})))
    else $error("pad duty exceeds drive");

  a_rescan_stall: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && (cfg_addr == REG_WINDOW_LEN) |=> in_stall)
    else $error("input taken during window rescan");

endmodule

bind windowed_pid_heater_control_top wphc_checker u_wphc_checker (.*);

`default_nettype wire
